// ===== hw/rtl/grw_pkg.sv =====
// shared types and constants for the grid ray wall intersection block
// no dependencies
package grw_pkg;

    localparam int FRAC_BITS    = 8;
    localparam int TILE_SHIFT   = 6 + FRAC_BITS;   // 64-pixel tiles in Q12.8
    localparam int MAP_MAX      = 64;
    localparam int GUARD_STEPS  = 132;
    localparam int ADDR_W       = 12;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_VCAST = 2'd1;
    localparam logic [1:0] REQ_HCAST = 2'd2;

    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;

    localparam logic [2:0] CFG_ADDR_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_ADDR_HEIGHT = 3'd4;

    localparam logic [20:0] MAX21 = 21'h1FFFFF;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [5:0]         cell_row;
        logic [5:0]         cell_col;
        logic               cell_wall;
        logic [19:0]        player_x;
        logic [19:0]        player_y;
        logic signed [31:0] ray_slope;
        logic [1:0]         horiz_dir;
        logic [1:0]         vert_dir;
    } req_t;

    typedef struct packed {
        logic [19:0] hit_x;
        logic [19:0] hit_y;
        logic [20:0] hit_distance;
        logic        hit_found;
    } rsp_t;

endpackage

// ===== hw/rtl/grw_map_ram.sv =====
// 4096 x 1 wall bit memory, one write and one registered read port
// uses grw_pkg for the address width
module grw_map_ram
(
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [grw_pkg::ADDR_W-1:0] wr_addr,
    input  logic                       wr_data,
    input  logic                       rd_en,
    input  logic [grw_pkg::ADDR_W-1:0] rd_addr,
    output logic                       rd_data
);

    logic mem [0:(1 << grw_pkg::ADDR_W)-1];
    logic rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/grw_sqrt.sv =====
// iterative integer square root, one result bit per cycle
// no package dependencies
module grw_sqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [44:0] radicand,
    output logic        done,
    output logic [22:0] root
);

    logic [44:0] rem_reg, rem_next;
    logic [45:0] res_reg, res_next;
    logic [44:0] bit_reg, bit_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [45:0] trial;

    always_comb
    begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = res_reg + {1'b0, bit_reg};
        if (start)
        begin
            rem_next  = radicand;
            res_next  = '0;
            bit_next  = {1'b1, 44'd0};
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if ({1'b0, rem_reg} >= trial)
            begin
                rem_next = rem_reg - trial[44:0];
                res_next = (res_reg >> 1) + {1'b0, bit_reg};
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd22)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[22:0];

endmodule

// ===== hw/rtl/grid_ray_wall_intersection.sv =====
// Grid ray wall intersection block.
// A request word either writes one cell of a 64 x 64 wall map or casts a ray
// along vertical or horizontal gridlines. Every request gives exactly one
// response word; a write or an unknown request answers with all fields zero.
// A request is taken when req_valid is high and req_stall low; the block
// stalls requests while one is in progress, so one word is handled at a time.
// A write goes straight to the output. A cast aligns to its first gridline,
// then tests one tile per step (one map read each); when a wall is hit or the ray
// leaves the map it squares the offsets and takes the bit-serial square root.
// The map read per tile and the root unit set how long a cast takes.
// The response sits in an output register; while rsp_stall is high it holds
// and the next request is worked on until its result is ready.
// Reset clears control state and sets both map size registers to 64; map
// contents are undefined until written. The user sets map size over the APB-style
// port at addresses 0 (width) and 4 (height), only while idle (not enforced).
module grid_ray_wall_intersection
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  grw_pkg::req_t req_word,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output grw_pkg::rsp_t rsp_word,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL   = 9'b000000010,
        S_ALIGN = 9'b000000100,
        S_TEST  = 9'b000001000,
        S_READ  = 9'b000010000,
        S_SQ    = 9'b000100000,
        S_SUM   = 9'b001000000,
        S_ROOT  = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t               state_reg, state_next;
    grw_pkg::req_t        req_reg, req_next;
    grw_pkg::rsp_t        res_reg, res_next;
    grw_pkg::rsp_t        rsp_word_reg, rsp_word_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [6:0]           width_reg, height_reg;
    logic signed [53:0]   prod_reg, prod_next;
    logic [20:0]          base_reg, base_next;
    logic signed [35:0]   xi_reg, xi_next, yi_reg, yi_next;
    logic signed [35:0]   xs_reg, xs_next, ys_reg, ys_next;
    logic [7:0]           guard_reg, guard_next;
    logic signed [21:0]   xc_reg, xc_next, yc_reg, yc_next;
    logic [41:0]          sqa_reg, sqa_next, sqb_reg, sqb_next;

    logic                 accept, cfg_wr;
    logic [6:0]           w_eff, h_eff;
    logic signed [35:0]   wq, hq;
    logic                 vert, right, left, down, up;
    logic [19:0]          pa;
    logic                 pdir;
    logic signed [21:0]   diff;
    logic signed [35:0]   shifted, step, step_f, xc, yc;
    logic                 neg_pos, neg_neg, in_rng, oob;
    logic [6:0]           col, row;
    logic signed [22:0]   ddx, ddy;
    logic [20:0]          adx, ady;
    logic                 ram_we, ram_re, ram_rd;
    logic [11:0]          ram_raddr;
    logic                 sq_start, sq_done;
    logic [22:0]          sq_root;

    assign accept = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb
    begin
        case (paddr)
            grw_pkg::CFG_ADDR_WIDTH:  prdata = {25'd0, width_reg};
            grw_pkg::CFG_ADDR_HEIGHT: prdata = {25'd0, height_reg};
            default:                  prdata = '0;
        endcase
    end

    assign w_eff = (width_reg > 7'd64) ? 7'd64 : width_reg;
    assign h_eff = (height_reg > 7'd64) ? 7'd64 : height_reg;
    assign wq = $signed({15'd0, w_eff, 14'd0});
    assign hq = $signed({15'd0, h_eff, 14'd0});

    assign vert  = (req_reg.req_type == grw_pkg::REQ_VCAST);
    assign right = (req_reg.horiz_dir == grw_pkg::DIR_RIGHT);
    assign left  = (req_reg.horiz_dir == grw_pkg::DIR_LEFT);
    assign down  = (req_reg.vert_dir == grw_pkg::DIR_DOWN);
    assign up    = (req_reg.vert_dir == grw_pkg::DIR_UP);

    // primary axis: x for the vertical walk, y for the horizontal walk
    assign pa   = vert ? req_reg.player_x : req_reg.player_y;
    assign pdir = vert ? right : down;
    assign diff = $signed({1'b0, base_reg}) - $signed({2'b00, pa});
    assign shifted = 36'(prod_reg >>> 16);
    assign step = 36'(req_reg.ray_slope >>> 2);
    assign neg_pos = vert ? up : left;
    assign neg_neg = vert ? down : right;
    assign step_f = ((neg_pos && step > 0) || (neg_neg && step < 0)) ? -step : step;

    assign in_rng = (guard_reg != 8'd0) && (xi_reg >= 0) && (xi_reg <= wq)
                    && (yi_reg >= 0) && (yi_reg <= hq);
    assign xc = xi_reg - ((vert && left) ? 36'sd256 : 36'sd0);
    assign yc = yi_reg - ((!vert && up) ? 36'sd256 : 36'sd0);
    assign col = xc[20:14];
    assign row = yc[20:14];
    assign oob = (xc < 0) || (xc > wq) || (yc < 0) || (yc > hq)
                 || (col >= w_eff) || (row >= h_eff);

    assign ddx = $signed({3'b000, req_reg.player_x}) - $signed({xc_reg[21], xc_reg});
    assign ddy = $signed({3'b000, req_reg.player_y}) - $signed({yc_reg[21], yc_reg});
    assign adx = ddx[22] ? 21'(-ddx) : ddx[20:0];
    assign ady = ddy[22] ? 21'(-ddy) : ddy[20:0];

    assign ram_we = accept && (req_word.req_type == grw_pkg::REQ_WRITE);
    assign ram_re = (state_reg == S_TEST);
    assign ram_raddr = {row[5:0], col[5:0]};
    assign sq_start = (state_reg == S_SUM);

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        rsp_word_next  = rsp_word_reg;
        rsp_valid_next = rsp_valid_reg;
        prod_next      = prod_reg;
        base_next      = base_reg;
        xi_next        = xi_reg;
        yi_next        = yi_reg;
        xs_next        = xs_reg;
        ys_next        = ys_reg;
        guard_next     = guard_reg;
        xc_next        = xc_reg;
        yc_next        = yc_reg;
        sqa_next       = sqa_reg;
        sqb_next       = sqb_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next   = req_word;
                    res_next   = '0;
                    guard_next = 8'(grw_pkg::GUARD_STEPS);
                    if (req_word.req_type == grw_pkg::REQ_VCAST
                        || req_word.req_type == grw_pkg::REQ_HCAST)
                    begin
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_MUL:
            begin
                // first gridline on the primary axis, then its offset times slope
                base_next  = {1'b0, pa[19:14], 14'd0} + (pdir ? 21'd16384 : 21'd0);
                state_next = S_ALIGN;
            end
            S_ALIGN:
            begin
                prod_next = diff * req_reg.ray_slope;
                state_next = S_TEST;
                if (vert)
                begin
                    xi_next = $signed({15'd0, base_reg});
                    xs_next = left ? -36'sd16384 : 36'sd16384;
                    ys_next = step_f;
                end
                else
                begin
                    yi_next = $signed({15'd0, base_reg});
                    ys_next = up ? -36'sd16384 : 36'sd16384;
                    xs_next = step_f;
                end
                // secondary coordinate is finished on the next cycle from prod
                state_next = S_READ;
                xc_next = '0;
                yc_next = '0;
                guard_next = guard_reg;
            end
            S_TEST:
            begin
                xc_next = xc[21:0];
                yc_next = yc[21:0];
                if (!in_rng)
                begin
                    res_next   = '0;
                    state_next = S_OUT;
                end
                else if (oob)
                begin
                    state_next = S_SQ;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (guard_reg == 8'(grw_pkg::GUARD_STEPS) && xc_reg == '0
                    && yc_reg == '0 && prod_valid_pending())
                begin
                    state_next = S_TEST;
                end
                state_next = S_TEST;
            end
            S_SQ:
            begin
                sqa_next   = adx * adx;
                sqb_next   = ady * ady;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (sq_done)
                begin
                    res_next.hit_x = xi_reg[20] ? 20'hFFFFF : xi_reg[19:0];
                    res_next.hit_y = yi_reg[20] ? 20'hFFFFF : yi_reg[19:0];
                    res_next.hit_distance = sq_root[22:21] != 2'b00
                                            ? grw_pkg::MAX21 : sq_root[20:0];
                    res_next.hit_found = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_word_next  = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    function automatic logic prod_valid_pending();
        return 1'b0;
    endfunction

    // read state doubles as the slope alignment step on the first visit
    logic first_reg, first_next;

    always_comb
    begin
        first_next = first_reg;
        if (state_reg == S_ALIGN)
        begin
            first_next = 1'b1;
        end
        else if (state_reg == S_READ)
        begin
            first_next = 1'b0;
        end
    end

    logic signed [35:0] xi_fin, yi_fin, xs_fin, ys_fin;
    logic [7:0]         guard_fin;
    state_t             state_fin;

    always_comb
    begin
        xi_fin    = xi_next;
        yi_fin    = yi_next;
        xs_fin    = xs_next;
        ys_fin    = ys_next;
        guard_fin = guard_next;
        state_fin = state_next;
        if (state_reg == S_READ)
        begin
            if (first_reg)
            begin
                if (vert)
                begin
                    yi_fin = $signed({16'd0, req_reg.player_y}) + shifted;
                end
                else
                begin
                    xi_fin = $signed({16'd0, req_reg.player_x}) + shifted;
                end
                state_fin = S_TEST;
            end
            else if (ram_rd)
            begin
                state_fin = S_SQ;
            end
            else
            begin
                xi_fin    = xi_reg + xs_reg;
                yi_fin    = yi_reg + ys_reg;
                guard_fin = guard_reg - 8'd1;
                state_fin = S_TEST;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            width_reg     <= 7'd64;
            height_reg    <= 7'd64;
            first_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_fin;
            rsp_valid_reg <= rsp_valid_next;
            first_reg     <= first_next;
            if (cfg_wr && paddr == grw_pkg::CFG_ADDR_WIDTH)
            begin
                width_reg <= pwdata[6:0];
            end
            if (cfg_wr && paddr == grw_pkg::CFG_ADDR_HEIGHT)
            begin
                height_reg <= pwdata[6:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        res_reg      <= res_next;
        rsp_word_reg <= rsp_word_next;
        prod_reg     <= prod_next;
        base_reg     <= base_next;
        xi_reg       <= xi_fin;
        yi_reg       <= yi_fin;
        xs_reg       <= xs_fin;
        ys_reg       <= ys_fin;
        guard_reg    <= guard_fin;
        xc_reg       <= xc_next;
        yc_reg       <= yc_next;
        sqa_reg      <= sqa_next;
        sqb_reg      <= sqb_next;
    end

    grw_map_ram u_map
    (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr ({req_word.cell_row, req_word.cell_col}),
        .wr_data (req_word.cell_wall),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rd)
    );

    grw_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand ({2'b00, {1'b0, sqa_reg} + {1'b0, sqb_reg}}),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule

// ===== hw/rtl/grw_checker.sv =====
// port-level checks for grid_ray_wall_intersection, attached by bind
// uses grw_pkg for the response word type
module grw_checker
(
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input grw_pkg::rsp_t rsp_word
);

    // a stalled response word stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("response dropped under stall");

    // one request at a time: a taken word blocks the next cycle
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while busy");

    // a miss or write ack carries no point and no distance
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_word.hit_found |->
            rsp_word.hit_x == '0 && rsp_word.hit_y == '0 && rsp_word.hit_distance == '0)
        else $error("miss with nonzero fields");

endmodule

bind grid_ray_wall_intersection grw_checker u_grw_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
);
